/* sv/pcps_pkg.sv */
// Shared types and constants for the per-chip PLL configuration scheduler.
`timescale 1ns / 1ps

package pcps_pkg;

  localparam int DEF_BOARDS          = 4;
  localparam int DEF_CHIPS_PER_BOARD = 16;

  localparam int WORD_W     = 32;
  localparam int BOARD_W    = 2;
  localparam int CHIP_W     = 4;
  localparam int SERVED_W   = 6;
  localparam int OPCODE_W   = 2;
  localparam int ENTRY_W    = 3 * WORD_W + 1;
  localparam int IN_DATA_W  = 104;
  localparam int OUT_DATA_W = 104;

  localparam logic [WORD_W-1:0] DEFAULT_WORD = 32'd1;

  typedef enum logic [OPCODE_W-1:0] {
    OP_WORK    = 2'd0,
    OP_SET_ONE = 2'd1,
    OP_SET_ALL = 2'd2,
    OP_UNUSED  = 2'd3
  } pcps_op_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FILL,
    ST_WORK
  } pcps_state_t;

  typedef struct packed {
    logic [WORD_W-1:0]   w0;
    logic [WORD_W-1:0]   w1;
    logic [WORD_W-1:0]   w2;
    logic                was_pending;
    logic [SERVED_W-1:0] slot;
  } pcps_res_t;

  typedef struct packed {
    logic      load;
    pcps_res_t res;
  } pcps_load_t;

endpackage

/* sv/pcps_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module pcps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* sv/pcps_seq.sv */
// Sequencer: clear sweep, slot writes, broadcast fill and work read-modify-write.
`timescale 1ns / 1ps

module pcps_seq
  import pcps_pkg::*;
#(
  parameter int BOARDS          = DEF_BOARDS,
  parameter int CHIPS_PER_BOARD = DEF_CHIPS_PER_BOARD,
  localparam int SLOTS  = BOARDS * CHIPS_PER_BOARD,
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [OPCODE_W-1:0] in_opcode,
  input  logic [BOARD_W-1:0]  board_sel,
  input  logic [CHIP_W-1:0]   chip_sel,
  input  logic [WORD_W-1:0]   pll_in0,
  input  logic [WORD_W-1:0]   pll_in1,
  input  logic [WORD_W-1:0]   pll_in2,
  output logic                ram_we,
  output logic [SLOT_W-1:0]   ram_waddr,
  output logic [ENTRY_W-1:0]  ram_wdata,
  output logic [SLOT_W-1:0]   ram_raddr,
  input  logic [ENTRY_W-1:0]  ram_rdata,
  input  logic                out_free,
  output pcps_load_t          ld
);

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

  pcps_state_t           state_r, state_nxt;
  logic [SLOT_W-1:0]     ptr_r, ptr_nxt;
  logic [SLOT_W-1:0]     cnt_r, cnt_nxt;
  logic [3*WORD_W-1:0]   fill_r, fill_nxt;
  logic                  in_range;
  logic [SLOT_W-1:0]     set_slot;
  logic                  pend;

  assign in_range = (int'(board_sel) < BOARDS) && (int'(chip_sel) < CHIPS_PER_BOARD);
  assign set_slot = SLOT_W'(int'(board_sel) * CHIPS_PER_BOARD + int'(chip_sel));
  assign pend     = ram_rdata[ENTRY_W-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      ptr_r   <= LAST_SLOT;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      ptr_r   <= ptr_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fill_r <= fill_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    ptr_nxt   = ptr_r;
    cnt_nxt   = cnt_r;
    fill_nxt  = fill_r;
    in_tready = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = ptr_r;
    ram_wdata = '0;
    ram_raddr = ptr_r;
    ld        = '0;
    case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_r;
        ram_wdata = '0;
        if (cnt_r == LAST_SLOT) begin
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          case (pcps_op_t'(in_opcode))
            OP_WORK: begin
              state_nxt = ST_WORK;
            end
            OP_SET_ONE: begin
              if (in_range) begin
                ram_we    = 1'b1;
                ram_waddr = set_slot;
                ram_wdata = {1'b1, pll_in2, pll_in1, pll_in0};
              end
            end
            OP_SET_ALL: begin
              fill_nxt  = {pll_in2, pll_in1, pll_in0};
              cnt_nxt   = '0;
              state_nxt = ST_FILL;
            end
            default: begin
            end
          endcase
        end
      end
      ST_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_r;
        ram_wdata = {1'b1, fill_r};
        if (cnt_r == LAST_SLOT) begin
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_WORK: begin
        if (out_free) begin
          ld.load            = 1'b1;
          ld.res.was_pending = pend;
          ld.res.slot        = SERVED_W'(ptr_r);
          if (pend) begin
            ld.res.w0 = ram_rdata[WORD_W-1:0];
            ld.res.w1 = ram_rdata[2*WORD_W-1:WORD_W];
            ld.res.w2 = ram_rdata[3*WORD_W-1:2*WORD_W];
          end else begin
            ld.res.w0 = DEFAULT_WORD;
            ld.res.w1 = DEFAULT_WORD;
            ld.res.w2 = DEFAULT_WORD;
          end
          ram_we    = pend;
          ram_waddr = ptr_r;
          ram_wdata = {1'b0, ram_rdata[3*WORD_W-1:0]};
          ptr_nxt   = (ptr_r == '0) ? LAST_SLOT : ptr_r - 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

/* sv/pcps_obuf.sv */
// Output register stage for served work results.
`timescale 1ns / 1ps

module pcps_obuf
  import pcps_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  pcps_load_t            ld,
  output logic                  out_free,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tuser
);

  logic      valid_r, valid_nxt;
  pcps_res_t res_r, res_nxt;

  assign out_free = !valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  always_comb begin
    valid_nxt = valid_r;
    res_nxt   = res_r;
    if (ld.load) begin
      valid_nxt = 1'b1;
      res_nxt   = ld.res;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {2'b00, res_r.slot, res_r.w2, res_r.w1, res_r.w0};
  assign out_tuser  = res_r.was_pending;

endmodule

/* sv/per_chip_pll_config_scheduler.sv */
// Top level of the per-chip PLL configuration scheduler.
//
//  channel | dir | payload                                               | handshake
//  in_     | in  | tdata: board_sel, chip_sel, pll_in0..2; tuser: opcode | tvalid/tready
//  out_    | out | tdata: pll_out0..2, slot_served; tuser: was_pending   | tvalid/tready
//
//  Work item: slot memory read, then output load and write-back.
//  Set one: a single slot write when board and chip are in range. Set all: one memory write per slot.
//  After reset a clearing pass writes every slot before the first transaction.
//  A work result waits in the sequencer while the output register is still full.
`timescale 1ns / 1ps

module per_chip_pll_config_scheduler
  import pcps_pkg::*;
#(
  parameter int BOARDS          = DEF_BOARDS,
  parameter int CHIPS_PER_BOARD = DEF_CHIPS_PER_BOARD
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [1:0] board_sel, [5:2] chip_sel, [37:6] pll_in0, [69:38] pll_in1, [101:70] pll_in2
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // [1:0] opcode
  input  logic [OPCODE_W-1:0]   in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [31:0] pll_out0, [63:32] pll_out1, [95:64] pll_out2, [101:96] slot_served
  output logic [OUT_DATA_W-1:0] out_tdata,
  // [0] was_pending
  output logic                  out_tuser
);

  localparam int SLOTS  = BOARDS * CHIPS_PER_BOARD;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic               ram_we;
  logic [SLOT_W-1:0]  ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [SLOT_W-1:0]  ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  logic               out_free;
  pcps_load_t         ld;

  pcps_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  pcps_seq #(
    .BOARDS          (BOARDS),
    .CHIPS_PER_BOARD (CHIPS_PER_BOARD)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_opcode (in_tuser),
    .board_sel (in_tdata[1:0]),
    .chip_sel  (in_tdata[5:2]),
    .pll_in0   (in_tdata[37:6]),
    .pll_in1   (in_tdata[69:38]),
    .pll_in2   (in_tdata[101:70]),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .out_free  (out_free),
    .ld        (ld)
  );

  pcps_obuf u_obuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .ld         (ld),
    .out_free   (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
